// ===== rtl/xxh_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh_pkg: shared types and constants of the XXH64 stream hasher
// Primes, datapath operation codes, operand selects and the command and
// status records between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package xxh_pkg;

   localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
   localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
   localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
   localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
   localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

   // datapath operations, one per cycle
   typedef enum logic [4:0] {
      OP_NOP,
      OP_MUL_GO,     // start multiplier on selected operand and prime
      OP_T_MUL,      // t = product
      OP_H_MUL,      // h = product
      OP_T_ADDROT,   // t = rotl(acc[idx] + t, 31)
      OP_T_ROT,      // t = rotl(t, 31)
      OP_ACC_WR,     // acc[idx] = t, mark a stripe folded
      OP_H_MERGE,    // h = lane merge sum
      OP_H_P5,       // h = prime 5
      OP_H_XOR,      // h ^= t
      OP_H_ADDK,     // h += selected prime
      OP_H_ADDLEN,   // h += message length
      OP_H_XR27,     // h = rotl(h ^ t, 27)
      OP_H_XR23,     // h = rotl(h ^ t, 23)
      OP_H_XR11,     // h = rotl(h ^ t, 11)
      OP_H_SX33,     // h ^= h >> 33
      OP_H_SX29,     // h ^= h >> 29
      OP_H_SX32,     // h ^= h >> 32
      OP_DIG_LD      // digest = h, state back to initial values
   } op_type;

   typedef enum logic [2:0] {
      ASRC_BUF,
      ASRC_ACC,
      ASRC_T,
      ASRC_H,
      ASRC_WLO,
      ASRC_BYTE
   } asel_type;

   typedef enum logic [2:0] {
      KSEL_P1,
      KSEL_P2,
      KSEL_P3,
      KSEL_P4,
      KSEL_P5
   } ksel_type;

   typedef struct packed {
      logic     take;   // capture the input transaction
      op_type   op;
      asel_type asel;
      ksel_type ksel;
      logic [2:0] idx;  // lane or byte position
   } cmd_type;

   typedef struct packed {
      logic       fold_pend;
      logic       last;
      logic       folded;
      logic [1:0] held;
      logic [2:0] tail_n;
      logic       mul_done;
   } status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
      rotl64 = (x << r) | (x >> (7'd64 - {1'b0, r}));
   endfunction

   function automatic logic [63:0] prime_of(input ksel_type k);
      logic [63:0] v;
      unique case (k)
         KSEL_P1: v = PRIME1;
         KSEL_P2: v = PRIME2;
         KSEL_P3: v = PRIME3;
         KSEL_P4: v = PRIME4;
         KSEL_P5: v = PRIME5;
         default: v = PRIME1;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/xxh_mul.sv =====
// ----------------------------------------------------------------------------
// xxh_mul: sequential 64x64 multiplier, low 64 bits
// One 32x32 partial product per cycle; with start high in one cycle the
// product and a one-cycle done pulse appear after the lo*lo, lo*hi and hi*lo steps.
// ----------------------------------------------------------------------------
`default_nettype none
module xxh_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      product
);
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [31:0] pa, pb;
   logic [63:0] prod;

   // partial product select
   always_comb begin
      unique case (step_ff)
         2'd2: begin pa = a_ff[31:0];  pb = b_ff[63:32]; end
         2'd3: begin pa = a_ff[63:32]; pb = b_ff[31:0];  end
         default: begin pa = a_ff[31:0]; pb = b_ff[31:0]; end
      endcase
      prod = 64'(pa) * 64'(pb);
   end

   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = 2'd1;
      end else if (step_ff == 2'd1) begin
         acc_in  = prod;
         step_in = 2'd2;
      end else if (step_ff != 2'd0) begin
         acc_in  = acc_ff + {prod[31:0], 32'b0};
         step_in = (step_ff == 2'd3) ? 2'd0 : step_ff + 2'd1;
         done_in = (step_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ===== rtl/xxh_datapath.sv =====
// ----------------------------------------------------------------------------
// xxh_datapath: hash state registers and operations
// Holds the lanes, stripe buffer, length, last word and running hash, and
// executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module xxh_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire xxh_pkg::cmd_type cmd,
   input  wire logic [63:0]      data_word,
   input  wire logic [3:0]       byte_count,
   input  wire logic             last_word,
   output xxh_pkg::status_type   status,
   output logic [63:0]           digest
);
   import xxh_pkg::*;

   logic [63:0] acc_ff [4];
   logic [63:0] buf_ff [4];
   logic [63:0] len_ff, w_ff, t_ff, h_ff, dig_ff;
   logic [63:0] t_in, h_in;
   logic [1:0]  held_ff;
   logic [2:0]  n_ff;
   logic        last_ff, folded_ff, pend_ff;
   logic [3:0]  n_eff;
   logic        push;
   logic [63:0] mul_a, mul_p;
   logic        mul_done;
   logic [1:0]  lane;

   assign lane = cmd.idx[1:0];

   // clamp of the byte count; a full word goes into the stripe buffer
   always_comb begin
      if (!last_word || byte_count > 4'd8) n_eff = 4'd8;
      else                                 n_eff = byte_count;
      push = (n_eff == 4'd8);
   end

   // multiplier operand
   always_comb begin
      unique case (cmd.asel)
         ASRC_BUF:  mul_a = buf_ff[lane];
         ASRC_ACC:  mul_a = acc_ff[lane];
         ASRC_T:    mul_a = t_ff;
         ASRC_H:    mul_a = h_ff;
         ASRC_WLO:  mul_a = {32'b0, w_ff[31:0]};
         ASRC_BYTE: mul_a = {56'b0, 8'(w_ff >> {cmd.idx, 3'b000})};
         default:   mul_a = t_ff;
      endcase
   end

   xxh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.op == OP_MUL_GO),
      .a       (mul_a),
      .b       (prime_of(cmd.ksel)),
      .done    (mul_done),
      .product (mul_p)
   );

   // scratch and hash updates
   always_comb begin
      t_in = t_ff;
      h_in = h_ff;
      unique case (cmd.op)
         OP_T_MUL:    t_in = mul_p;
         OP_H_MUL:    h_in = mul_p;
         OP_T_ADDROT: t_in = rotl64(acc_ff[lane] + t_ff, 6'd31);
         OP_T_ROT:    t_in = rotl64(t_ff, 6'd31);
         OP_H_MERGE:  h_in = rotl64(acc_ff[0], 6'd1) + rotl64(acc_ff[1], 6'd7)
                           + rotl64(acc_ff[2], 6'd12) + rotl64(acc_ff[3], 6'd18);
         OP_H_P5:     h_in = PRIME5;
         OP_H_XOR:    h_in = h_ff ^ t_ff;
         OP_H_ADDK:   h_in = h_ff + prime_of(cmd.ksel);
         OP_H_ADDLEN: h_in = h_ff + len_ff;
         OP_H_XR27:   h_in = rotl64(h_ff ^ t_ff, 6'd27);
         OP_H_XR23:   h_in = rotl64(h_ff ^ t_ff, 6'd23);
         OP_H_XR11:   h_in = rotl64(h_ff ^ t_ff, 6'd11);
         OP_H_SX33:   h_in = h_ff ^ (h_ff >> 33);
         OP_H_SX29:   h_in = h_ff ^ (h_ff >> 29);
         OP_H_SX32:   h_in = h_ff ^ (h_ff >> 32);
         default:     ;
      endcase
   end

   // message state: reset and digest load return it to initial values
   always_ff @(posedge clock) begin
      if (reset || cmd.op == OP_DIG_LD) begin
         acc_ff[0] <= PRIME1 + PRIME2;
         acc_ff[1] <= PRIME2;
         acc_ff[2] <= 64'd0;
         acc_ff[3] <= 64'd0 - PRIME1;
         len_ff    <= 64'd0;
         held_ff   <= 2'd0;
         folded_ff <= 1'b0;
         pend_ff   <= 1'b0;
         last_ff   <= 1'b0;
         n_ff      <= 3'd0;
      end else if (cmd.take) begin
         len_ff  <= len_ff + 64'(n_eff);
         last_ff <= last_word;
         n_ff    <= push ? 3'd0 : n_eff[2:0];
         pend_ff <= push && (held_ff == 2'd3);
         if (push) held_ff <= held_ff + 2'd1;
      end else if (cmd.op == OP_ACC_WR) begin
         acc_ff[lane] <= t_ff;
         folded_ff    <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         w_ff <= data_word;
         if (push) buf_ff[held_ff] <= data_word;
      end
      t_ff <= t_in;
      h_ff <= h_in;
      if (cmd.op == OP_DIG_LD) dig_ff <= h_ff;
   end

   always_comb begin
      status.fold_pend = pend_ff;
      status.last      = last_ff;
      status.folded    = folded_ff;
      status.held      = held_ff;
      status.tail_n    = n_ff;
      status.mul_done  = mul_done;
   end

   assign digest = dig_ff;
endmodule
`default_nettype wire

// ===== rtl/xxh_ctrl.sv =====
// ----------------------------------------------------------------------------
// xxh_ctrl: sequencer of the XXH64 hasher
// Accepts words, runs stripe folds and the finalization as a sequence of
// datapath commands, and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module xxh_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire xxh_pkg::status_type status,
   output xxh_pkg::cmd_type         cmd
);
   import xxh_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE, ST_CHK,
      ST_F_M1, ST_F_AR, ST_F_M2, ST_F_WR,
      ST_FIN,
      ST_M_M1, ST_M_RT, ST_M_M2, ST_M_X, ST_M_M3, ST_M_A,
      ST_LEN,
      ST_T_CHK, ST_T_M1, ST_T_RT, ST_T_M2, ST_T_X, ST_T_M3, ST_T_A,
      ST_Q_CHK, ST_Q_M1, ST_Q_X, ST_Q_M2, ST_Q_A,
      ST_B_CHK, ST_B_M1, ST_B_X, ST_B_M2,
      ST_V1, ST_V2, ST_V3, ST_V4, ST_V5,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in, mul_next;
   logic [2:0] i_ff, i_in;
   logic       wait_ff, wait_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_mul, mul_to_h;
   asel_type   mul_asel;
   ksel_type   mul_ksel;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.take     = 1'b0;
      cmd.op       = OP_NOP;
      cmd.asel     = ASRC_T;
      cmd.ksel     = KSEL_P1;
      cmd.idx      = i_ff;
      is_mul       = 1'b0;
      mul_to_h     = 1'b0;
      mul_asel     = ASRC_T;
      mul_ksel     = KSEL_P1;
      mul_next     = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid) state_in = ST_CHK;
         end
         ST_CHK: begin
            i_in = 3'd0;
            if (status.fold_pend) state_in = ST_F_M1;
            else if (status.last) state_in = ST_FIN;
            else                  state_in = ST_IDLE;
         end
         // stripe fold, one lane at a time
         ST_F_M1: begin
            is_mul = 1'b1; mul_asel = ASRC_BUF; mul_ksel = KSEL_P2; mul_next = ST_F_AR;
         end
         ST_F_AR: begin cmd.op = OP_T_ADDROT; state_in = ST_F_M2; end
         ST_F_M2: begin
            is_mul = 1'b1; mul_asel = ASRC_T; mul_ksel = KSEL_P1; mul_next = ST_F_WR;
         end
         ST_F_WR: begin
            cmd.op = OP_ACC_WR;
            i_in   = i_ff + 3'd1;
            if (i_ff == 3'd3) state_in = status.last ? ST_FIN : ST_IDLE;
            else              state_in = ST_F_M1;
         end
         ST_FIN: begin
            i_in = 3'd0;
            if (status.folded) begin
               cmd.op   = OP_H_MERGE;
               state_in = ST_M_M1;
            end else begin
               cmd.op   = OP_H_P5;
               state_in = ST_LEN;
            end
         end
         // lane merge
         ST_M_M1: begin
            is_mul = 1'b1; mul_asel = ASRC_ACC; mul_ksel = KSEL_P2; mul_next = ST_M_RT;
         end
         ST_M_RT: begin cmd.op = OP_T_ROT; state_in = ST_M_M2; end
         ST_M_M2: begin
            is_mul = 1'b1; mul_asel = ASRC_T; mul_ksel = KSEL_P1; mul_next = ST_M_X;
         end
         ST_M_X: begin cmd.op = OP_H_XOR; state_in = ST_M_M3; end
         ST_M_M3: begin
            is_mul = 1'b1; mul_to_h = 1'b1; mul_asel = ASRC_H; mul_ksel = KSEL_P1;
            mul_next = ST_M_A;
         end
         ST_M_A: begin
            cmd.op   = OP_H_ADDK;
            cmd.ksel = KSEL_P4;
            i_in     = i_ff + 3'd1;
            state_in = (i_ff == 3'd3) ? ST_LEN : ST_M_M1;
         end
         ST_LEN: begin
            cmd.op   = OP_H_ADDLEN;
            i_in     = 3'd0;
            state_in = ST_T_CHK;
         end
         // buffered 8-byte words
         ST_T_CHK: state_in = (i_ff < {1'b0, status.held}) ? ST_T_M1 : ST_Q_CHK;
         ST_T_M1: begin
            is_mul = 1'b1; mul_asel = ASRC_BUF; mul_ksel = KSEL_P2; mul_next = ST_T_RT;
         end
         ST_T_RT: begin cmd.op = OP_T_ROT; state_in = ST_T_M2; end
         ST_T_M2: begin
            is_mul = 1'b1; mul_asel = ASRC_T; mul_ksel = KSEL_P1; mul_next = ST_T_X;
         end
         ST_T_X: begin cmd.op = OP_H_XR27; state_in = ST_T_M3; end
         ST_T_M3: begin
            is_mul = 1'b1; mul_to_h = 1'b1; mul_asel = ASRC_H; mul_ksel = KSEL_P1;
            mul_next = ST_T_A;
         end
         ST_T_A: begin
            cmd.op   = OP_H_ADDK;
            cmd.ksel = KSEL_P4;
            i_in     = i_ff + 3'd1;
            state_in = ST_T_CHK;
         end
         // 4-byte step
         ST_Q_CHK: begin
            i_in     = 3'd0;
            state_in = (status.tail_n >= 3'd4) ? ST_Q_M1 : ST_B_CHK;
         end
         ST_Q_M1: begin
            is_mul = 1'b1; mul_asel = ASRC_WLO; mul_ksel = KSEL_P1; mul_next = ST_Q_X;
         end
         ST_Q_X: begin cmd.op = OP_H_XR23; state_in = ST_Q_M2; end
         ST_Q_M2: begin
            is_mul = 1'b1; mul_to_h = 1'b1; mul_asel = ASRC_H; mul_ksel = KSEL_P2;
            mul_next = ST_Q_A;
         end
         ST_Q_A: begin
            cmd.op   = OP_H_ADDK;
            cmd.ksel = KSEL_P3;
            i_in     = 3'd4;
            state_in = ST_B_CHK;
         end
         // single bytes
         ST_B_CHK: state_in = (i_ff < status.tail_n) ? ST_B_M1 : ST_V1;
         ST_B_M1: begin
            is_mul = 1'b1; mul_asel = ASRC_BYTE; mul_ksel = KSEL_P5; mul_next = ST_B_X;
         end
         ST_B_X: begin cmd.op = OP_H_XR11; state_in = ST_B_M2; end
         ST_B_M2: begin
            is_mul = 1'b1; mul_to_h = 1'b1; mul_asel = ASRC_H; mul_ksel = KSEL_P1;
            mul_next = ST_B_CHK;
            if (wait_ff && status.mul_done) i_in = i_ff + 3'd1;
         end
         // avalanche
         ST_V1: begin cmd.op = OP_H_SX33; state_in = ST_V2; end
         ST_V2: begin
            is_mul = 1'b1; mul_to_h = 1'b1; mul_asel = ASRC_H; mul_ksel = KSEL_P2;
            mul_next = ST_V3;
         end
         ST_V3: begin cmd.op = OP_H_SX29; state_in = ST_V4; end
         ST_V4: begin
            is_mul = 1'b1; mul_to_h = 1'b1; mul_asel = ASRC_H; mul_ksel = KSEL_P3;
            mul_next = ST_V5;
         end
         ST_V5: begin cmd.op = OP_H_SX32; state_in = ST_DONE; end
         // hand the digest to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_DIG_LD;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // shared multiply handshake: start once, write back on done
      if (is_mul) begin
         cmd.asel = mul_asel;
         cmd.ksel = mul_ksel;
         if (!wait_ff) begin
            cmd.op  = OP_MUL_GO;
            wait_in = 1'b1;
         end else if (status.mul_done) begin
            cmd.op   = mul_to_h ? OP_H_MUL : OP_T_MUL;
            wait_in  = 1'b0;
            state_in = mul_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= 3'd0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no transaction is taken while reset is held
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== rtl/xxhash64_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher: seed-zero XXH64 over a stream of 64-bit words
// Each word is taken and checked; the word completing a stripe adds lane
// folding, and every multiply goes through the shared multiplier handshake.
// The last word adds the lane merge (or loading prime 5 without a stripe),
// the length, the tail words, the 4-byte step, each byte, and the avalanche.
// Synchronous reset returns lanes, length and counters to initial values.
// ----------------------------------------------------------------------------
`default_nettype none
module xxhash64_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_digest
);
   import xxh_pkg::*;

   cmd_type    cmd;
   status_type status;

   xxh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   xxh_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_word  (req_data_word),
      .byte_count (req_byte_count),
      .last_word  (req_last_word),
      .status     (status),
      .digest     (rsp_digest)
   );
endmodule
`default_nettype wire
